// ----- design/top_k_rank_select_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef TOP_K_RANK_SELECT_MACROS_SVH
`define TOP_K_RANK_SELECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TKRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tkrs_pkg.sv -----
// Package with the record type, widths and ranking helpers for the top-K selector.
package tkrs_pkg;

  localparam int ID_W       = 16;
  localparam int SC_W       = 10;
  localparam int WC_W       = 5;
  localparam int TOT_W      = SC_W + 1;
  localparam int ID_BITS    = 16;
  localparam int SCORE_BITS = 10;
  localparam int MAX_WINNERS_DEF = 16;
  localparam int Q_DEPTH    = 2;

  localparam int ID_KEEP  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int SAT_BITS = (SCORE_BITS < SC_W) ? SCORE_BITS : SC_W;
  localparam logic [ID_W-1:0] ID_MASK   = ID_W'((64'd1 << ID_KEEP) - 64'd1);
  localparam logic [SC_W-1:0] SCORE_MAX = SC_W'((64'd1 << SAT_BITS) - 64'd1);

  typedef struct packed {
    logic            last;
    logic [ID_W-1:0] id;
    logic [SC_W-1:0] s1;
    logic [SC_W-1:0] s2;
  } rec_t;

  function automatic logic [SC_W-1:0] sat_score(input logic [SC_W-1:0] v);
    return (v > SCORE_MAX) ? SCORE_MAX : v;
  endfunction

  function automatic logic ranks_before(
    input logic [ID_W-1:0] id_a, input logic [SC_W-1:0] s1_a, input logic [SC_W-1:0] s2_a,
    input logic [ID_W-1:0] id_b, input logic [SC_W-1:0] s1_b, input logic [SC_W-1:0] s2_b);
    logic [TOT_W-1:0] ta;
    logic [TOT_W-1:0] tb;
    ta = {1'b0, s1_a} + {1'b0, s2_a};
    tb = {1'b0, s1_b} + {1'b0, s2_b};
    if (ta != tb) begin
      return ta > tb;
    end
    if (s1_a != s1_b) begin
      return s1_a > s1_b;
    end
    return id_a < id_b;
  endfunction

endpackage

// ----- design/top_k_rank_select.sv -----
// Top level of the streaming top-K record selector.
//
//   Channel   Handshake              Payload
//   in        start / busy           in_record_id, in_first_score, in_second_score,
//                                    in_last_record
//   out       out_valid (strobe)     out_winner_id, out_last_winner
//   cfg       cfg_valid / cfg_ready  cfg_winner_count
//
// A record is taken in one cycle and inserted into the ranked list in the next cycle
// the back end is free, so a batch streams at one item per cycle while busy is low.
// After the last record the winners are sorted by id, then one winner comes out
// per cycle; the two-entry queue keeps taking items while this runs, and busy rises
// only when it is full. Reset is synchronous and leaves the held list empty.
// The receiver cannot stall: every strobed winner is taken.
`include "top_k_rank_select_macros.svh"

module top_k_rank_select #(
  parameter int MAX_WINNERS = tkrs_pkg::MAX_WINNERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [tkrs_pkg::ID_W-1:0] in_record_id,
  input  logic [tkrs_pkg::SC_W-1:0] in_first_score,
  input  logic [tkrs_pkg::SC_W-1:0] in_second_score,
  input  logic                      in_last_record,
  output logic                      out_valid,
  output logic [tkrs_pkg::ID_W-1:0] out_winner_id,
  output logic                      out_last_winner,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tkrs_pkg::WC_W-1:0] cfg_winner_count
);
  import tkrs_pkg::*;

  logic            push;
  rec_t            push_rec;
  rec_t            head_rec;
  logic            q_empty;
  logic            q_full;
  logic            pop;
  logic [WC_W-1:0] winner_count_r, winner_count_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    winner_count_nxt = winner_count_r;
    if (cfg_valid && cfg_ready) begin
      winner_count_nxt = cfg_winner_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      winner_count_r <= WC_W'(1);
    end else begin
      winner_count_r <= winner_count_nxt;
    end
  end

  tkrs_front u_front (
    .start           (start),
    .busy            (busy),
    .in_record_id    (in_record_id),
    .in_first_score  (in_first_score),
    .in_second_score (in_second_score),
    .in_last_record  (in_last_record),
    .q_full          (q_full),
    .push            (push),
    .push_rec        (push_rec)
  );

  tkrs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  tkrs_back #(
    .MAX_WINNERS (MAX_WINNERS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .winner_count    (winner_count_r),
    .head_rec        (head_rec),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_winner_id   (out_winner_id),
    .out_last_winner (out_last_winner)
  );

  `TKRS_ASSERT_NOW(a_no_push_when_full, q_full, !push, "Item pushed into a full queue.")
  `TKRS_ASSERT_NOW(a_no_pop_when_empty, q_empty, !pop, "Item popped from an empty queue.")
  `TKRS_ASSERT_NEXT(a_gap_after_last, out_valid && out_last_winner, !out_valid,
    "Winner strobed right after the final winner of a batch.")
  `TKRS_ASSERT_NEXT(a_winners_contiguous, out_valid && !out_last_winner, out_valid,
    "Gap inside a batch of winners.")

endmodule

// ----- design/tkrs_front.sv -----
// Front end: accepts items, masks the id and saturates the scores.
module tkrs_front (
  input  logic                    start,
  output logic                    busy,
  input  logic [tkrs_pkg::ID_W-1:0] in_record_id,
  input  logic [tkrs_pkg::SC_W-1:0] in_first_score,
  input  logic [tkrs_pkg::SC_W-1:0] in_second_score,
  input  logic                    in_last_record,
  input  logic                    q_full,
  output logic                    push,
  output tkrs_pkg::rec_t          push_rec
);
  import tkrs_pkg::*;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_rec.last = in_last_record;
    push_rec.id   = in_record_id & ID_MASK;
    push_rec.s1   = sat_score(in_first_score);
    push_rec.s2   = sat_score(in_second_score);
  end

endmodule

// ----- design/tkrs_queue.sv -----
// Short queue of cleaned records between the front end and the ranking back end.
module tkrs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tkrs_pkg::rec_t push_rec,
  input  logic           pop,
  output tkrs_pkg::rec_t head_rec,
  output logic           empty,
  output logic           full
);
  import tkrs_pkg::*;

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(Q_DEPTH);

  rec_t          mem_r [Q_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == DEPTH_C);
  assign head_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/tkrs_back.sv -----
// Back end: insertion chain in rank order, id sort of the winners and result output.
module tkrs_back #(
  parameter int MAX_WINNERS = tkrs_pkg::MAX_WINNERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tkrs_pkg::WC_W-1:0] winner_count,
  input  tkrs_pkg::rec_t            head_rec,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      out_valid,
  output logic [tkrs_pkg::ID_W-1:0] out_winner_id,
  output logic                      out_last_winner
);
  import tkrs_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int KW = 7;
  localparam int CW = $clog2(MAX_WINNERS + 1);
  localparam logic [CW-1:0] LAST_PASS = CW'(MAX_WINNERS - 1);
  localparam logic [KW-1:0] MAX_K = KW'(MAX_WINNERS);

  logic [1:0]             state_r, state_nxt;
  logic [CW-1:0]          pass_r, pass_nxt;
  logic [ID_W-1:0]        id_r  [MAX_WINNERS];
  logic [ID_W-1:0]        id_nxt [MAX_WINNERS];
  logic [SC_W-1:0]        s1_r  [MAX_WINNERS];
  logic [SC_W-1:0]        s1_nxt [MAX_WINNERS];
  logic [SC_W-1:0]        s2_r  [MAX_WINNERS];
  logic [SC_W-1:0]        s2_nxt [MAX_WINNERS];
  logic [MAX_WINNERS-1:0] vld_r, vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [MAX_WINNERS-1:0] ins;
  logic [MAX_WINNERS-1:0] ins_prev;
  logic [ID_W-1:0]        src_id [MAX_WINNERS];
  logic [SC_W-1:0]        src_s1 [MAX_WINNERS];
  logic [SC_W-1:0]        src_s2 [MAX_WINNERS];
  logic [MAX_WINNERS-1:0] src_v;
  logic [MAX_WINNERS:0]   vld_ext;
  logic [KW-1:0]          k_eff;
  logic                   swap;

  assign out_valid       = out_valid_r;
  assign out_winner_id   = out_id_r;
  assign out_last_winner = out_last_r;
  assign vld_ext         = {1'b0, vld_r};

  always_comb begin
    if (winner_count == '0) begin
      k_eff = KW'(1);
    end else if ({{(KW - WC_W){1'b0}}, winner_count} > MAX_K) begin
      k_eff = MAX_K;
    end else begin
      k_eff = {{(KW - WC_W){1'b0}}, winner_count};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WINNERS; i++) begin
      ins[i] = !vld_r[i] || ranks_before(head_rec.id, head_rec.s1, head_rec.s2,
                                         id_r[i], s1_r[i], s2_r[i]);
    end
    ins_prev[0] = 1'b0;
    src_id[0]   = head_rec.id;
    src_s1[0]   = head_rec.s1;
    src_s2[0]   = head_rec.s2;
    src_v[0]    = 1'b1;
    for (int i = 1; i < MAX_WINNERS; i++) begin
      ins_prev[i] = ins[i-1];
      src_id[i]   = id_r[i-1];
      src_s1[i]   = s1_r[i-1];
      src_s2[i]   = s2_r[i-1];
      src_v[i]    = vld_r[i-1];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    id_nxt        = id_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    vld_nxt       = vld_r;
    out_valid_nxt = 1'b0;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    swap          = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (!q_empty) begin
          pop = 1'b1;
          for (int i = 0; i < MAX_WINNERS; i++) begin
            if (ins[i]) begin
              if (ins_prev[i]) begin
                id_nxt[i]  = src_id[i];
                s1_nxt[i]  = src_s1[i];
                s2_nxt[i]  = src_s2[i];
                vld_nxt[i] = src_v[i];
              end else begin
                id_nxt[i]  = head_rec.id;
                s1_nxt[i]  = head_rec.s1;
                s2_nxt[i]  = head_rec.s2;
                vld_nxt[i] = 1'b1;
              end
            end
          end
          if (head_rec.last) begin
            for (int i = 0; i < MAX_WINNERS; i++) begin
              if (KW'(i) >= k_eff) begin
                vld_nxt[i] = 1'b0;
              end
            end
            pass_nxt  = '0;
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        for (int i = 0; i + 1 < MAX_WINNERS; i++) begin
          if ((i % 2) == int'(pass_r[0])) begin
            swap = (!vld_r[i] && vld_r[i+1]) ||
                   (vld_r[i] && vld_r[i+1] && (id_r[i+1] < id_r[i]));
            if (swap) begin
              id_nxt[i]    = id_r[i+1];
              id_nxt[i+1]  = id_r[i];
              vld_nxt[i]   = vld_r[i+1];
              vld_nxt[i+1] = vld_r[i];
            end
          end
        end
        pass_nxt = pass_r + CW'(1);
        if (pass_r == LAST_PASS) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (vld_r[0]) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = id_r[0];
          out_last_nxt  = !vld_ext[1];
          for (int i = 0; i + 1 < MAX_WINNERS; i++) begin
            id_nxt[i] = id_r[i+1];
          end
          vld_nxt = vld_r >> 1;
          if (!vld_ext[1]) begin
            state_nxt = ST_RUN;
          end
        end else begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
        vld_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    s1_r     <= s1_nxt;
    s2_r     <= s2_nxt;
    pass_r   <= pass_nxt;
    out_id_r <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- tb/top_k_rank_select_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the top-K record selector, with a ranking scoreboard.
module top_k_rank_select_tb;
  localparam int MAX_SEL = tkrs_pkg::MAX_WINNERS_DEF;
  localparam int SETTLE_CYCLES = 3 * MAX_SEL + 8;

  typedef logic [tkrs_pkg::ID_W-1:0] id_t;
  typedef logic [tkrs_pkg::SC_W-1:0] score_t;
  typedef logic [tkrs_pkg::WC_W-1:0] count_t;
  typedef struct {
    id_t  id;
    logic last;
  } winner_t;

  class winner_scoreboard;
    id_t     held_id[MAX_SEL];
    score_t  held_first[MAX_SEL];
    score_t  held_second[MAX_SEL];
    int      held_n;
    count_t  select_count;
    winner_t due_q[$];
    int      errors;

    function new();
      held_n = 0;
      select_count = 1;
      errors = 0;
    endfunction

    function void set_count(count_t v);
      select_count = v;
    endfunction

    function score_t clip(score_t v);
      return (v > tkrs_pkg::SCORE_MAX) ? tkrs_pkg::SCORE_MAX : v;
    endfunction

    function bit outranks(id_t id_a, score_t f_a, score_t s_a,
                          id_t id_b, score_t f_b, score_t s_b);
      logic [tkrs_pkg::SC_W:0] sum_a;
      logic [tkrs_pkg::SC_W:0] sum_b;
      sum_a = {1'b0, f_a} + {1'b0, s_a};
      sum_b = {1'b0, f_b} + {1'b0, s_b};
      if (sum_a != sum_b) begin
        return sum_a > sum_b;
      end
      if (f_a != f_b) begin
        return f_a > f_b;
      end
      return id_a < id_b;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void note_record(id_t id, score_t f, score_t s, logic last);
      int      pos;
      int      i;
      int      k;
      int      n;
      int      ids[$];
      id_t     rid;
      score_t  rf;
      score_t  rs;
      winner_t w;
      rid = id & tkrs_pkg::ID_MASK;
      rf = clip(f);
      rs = clip(s);
      pos = 0;
      while (pos < held_n &&
             !outranks(rid, rf, rs, held_id[pos], held_first[pos], held_second[pos])) begin
        pos++;
      end
      if (pos < MAX_SEL) begin
        i = (held_n < MAX_SEL) ? held_n : MAX_SEL - 1;
        while (i > pos) begin
          held_id[i] = held_id[i-1];
          held_first[i] = held_first[i-1];
          held_second[i] = held_second[i-1];
          i--;
        end
        held_id[pos] = rid;
        held_first[pos] = rf;
        held_second[pos] = rs;
        if (held_n < MAX_SEL) begin
          held_n++;
        end
      end
      if (!last) begin
        return;
      end
      k = select_count;
      if (k < 1) begin
        k = 1;
      end
      if (k > MAX_SEL) begin
        k = MAX_SEL;
      end
      n = (held_n < k) ? held_n : k;
      for (i = 0; i < n; i++) begin
        ids.push_back(int'(held_id[i]));
      end
      ids.sort();
      for (i = 0; i < n; i++) begin
        w.id = id_t'(ids[i]);
        w.last = (i == n - 1);
        due_q.push_back(w);
      end
      held_n = 0;
    endfunction

    function void check_winner(id_t id, logic last);
      winner_t w;
      if (due_q.size() == 0) begin
        flag_error($sformatf("Unexpected winner: id %0d last %0b", id, last));
        return;
      end
      w = due_q.pop_front();
      if (w.id !== id || w.last !== last) begin
        flag_error($sformatf("Winner mismatch: expected id %0d last %0b, got id %0d last %0b",
                             w.id, w.last, id, last));
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  id_t    in_record_id;
  score_t in_first_score;
  score_t in_second_score;
  logic   in_last_record;
  logic   out_valid;
  id_t    out_winner_id;
  logic   out_last_winner;
  logic   cfg_valid;
  logic   cfg_ready;
  count_t cfg_winner_count;

  winner_scoreboard sb = new();
  int sent = 0;

  top_k_rank_select uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_record_id    (in_record_id),
    .in_first_score  (in_first_score),
    .in_second_score (in_second_score),
    .in_last_record  (in_last_record),
    .out_valid       (out_valid),
    .out_winner_id   (out_winner_id),
    .out_last_winner (out_last_winner),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_winner_count(cfg_winner_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_count(cfg_winner_count);
      end
      if (start && !busy) begin
        sb.note_record(in_record_id, in_first_score, in_second_score, in_last_record);
      end
      if (out_valid) begin
        sb.check_winner(out_winner_id, out_last_winner);
      end
    end
  end

  function automatic score_t pick_score();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return tkrs_pkg::SCORE_MAX;
      2: return score_t'($urandom_range(0, 3));
      default: return score_t'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic id_t pick_id();
    if ($urandom_range(0, 3) == 0) begin
      return id_t'($urandom_range(0, 15));
    end
    return id_t'($urandom_range(0, 65535));
  endfunction

  task automatic send_record(id_t id, score_t f, score_t s, logic last);
    @(negedge clk);
    start = 1'b1;
    in_record_id = id;
    in_first_score = f;
    in_second_score = s;
    in_last_record = last;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start = 1'b0;
    in_record_id = pick_id();
    in_first_score = pick_score();
    in_second_score = pick_score();
    in_last_record = $urandom_range(0, 1);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle(int extra);
    int guard;
    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_count(count_t v);
    settle(SETTLE_CYCLES);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_winner_count = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_winner_count = count_t'($urandom_range(0, 31));
  endtask

  task automatic send_batch(int len);
    for (int i = 0; i < len; i++) begin
      if (sent < 140 && $urandom_range(0, 3) == 0) begin
        pause($urandom_range(1, 14));
      end
      send_record(pick_id(), pick_score(), pick_score(), i == len - 1);
    end
  endtask

  initial begin
    count_t plan[8];
    int     phase;
    int     len;
    plan = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd17, 5'd5, 5'd16};
    rst_n = 1'b0;
    start = 1'b0;
    in_record_id = '0;
    in_first_score = '0;
    in_second_score = '0;
    in_last_record = 1'b0;
    cfg_valid = 1'b0;
    cfg_winner_count = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_record(16'd42, 10'd17, 10'd3, 1'b1);

    write_count(5'd16);
    send_record(16'hFFFF, 10'd1023, 10'd1023, 1'b0);
    send_record(16'h0000, 10'd0, 10'd0, 1'b0);
    send_record(16'd5, 10'd600, 10'd400, 1'b0);
    send_record(16'd3, 10'd400, 10'd600, 1'b0);
    send_record(16'd9, 10'd300, 10'd300, 1'b0);
    send_record(16'd7, 10'd300, 10'd300, 1'b0);
    send_record(16'd7, 10'd300, 10'd300, 1'b0);
    send_record(16'h8000, 10'd1023, 10'd0, 1'b0);
    send_record(16'h1234, 10'd0, 10'd1023, 1'b1);

    write_count(5'd0);
    send_record(16'd100, 10'd10, 10'd10, 1'b0);
    send_record(16'd99, 10'd10, 10'd10, 1'b0);
    send_record(16'd101, 10'd20, 10'd0, 1'b1);

    write_count(5'd31);
    send_record(16'hAAAA, 10'h2AA, 10'h155, 1'b0);
    send_record(16'h5555, 10'h155, 10'h2AA, 1'b1);

    phase = 0;
    while (sent < 160) begin
      write_count((phase < 8) ? plan[phase] : count_t'($urandom_range(0, 31)));
      phase++;
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 12);
        send_batch(len);
      end
    end

    settle(SETTLE_CYCLES);
    if (sb.pending() != 0) begin
      sb.flag_error($sformatf("%0d expected winners never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/tkrs_pkg.sv
design/tkrs_front.sv
design/tkrs_queue.sv
design/tkrs_back.sv
design/top_k_rank_select.sv
tb/top_k_rank_select_tb.sv
